### rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg: shared types and constants of the RGB to HSV converter
// Field widths, divider sizing, sector codes and stage control structs.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // Pixel and result field widths
  localparam int unsigned PIX_W = 8;
  localparam int unsigned HUE_W = 9;
  localparam int unsigned PCT_W = 7;

  // Hue numerator in signed form, wide enough for 360 * 255 plus sign
  localparam int unsigned NUM_W = 19;

  // Divider: 18-bit dividend, 8-bit divisor, reciprocal scaled by 2^18
  localparam int unsigned DIV_NUM_W   = 18;
  localparam int unsigned DIV_DEN_W   = 8;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned QUOT_W      = DIV_NUM_W;
  localparam int unsigned REM_W       = DIV_DEN_W + 1;

  // Arithmetic constants
  localparam int unsigned HUE_STEP_DEG = 60;
  localparam int unsigned HUE_G_DEG    = 120;
  localparam int unsigned HUE_B_DEG    = 240;
  localparam int unsigned HUE_FULL_DEG = 360;
  localparam int unsigned PCT_SCALE    = 100;
  localparam int unsigned VAL_BIAS     = 127;  // half of 255, rounded down

  // Channel that holds the maximum
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // Stage enables of the front end
  typedef struct packed {
    logic a;
    logic b;
  } prep_en_t;

  // Stage enables of a divider
  typedef struct packed {
    logic s1;
    logic s2;
  } div_en_t;

  // Front-end result handed to the dividers
  typedef struct packed {
    logic [DIV_NUM_W-1:0] hue_num;
    logic [DIV_NUM_W-1:0] sat_num;
    logic [DIV_DEN_W-1:0] diff;
    logic [DIV_DEN_W-1:0] mx;
    logic [PCT_W-1:0]     val;
    logic                 zero;
  } prep_t;

endpackage

### rtl/rgbhsv_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_if: valid/ready channels of the RGB to HSV converter
// Pixel channel in, HSV channel out.
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;
  logic                       valid;
  logic                       ready;
  logic [rgbhsv_pkg::PIX_W-1:0] red;
  logic [rgbhsv_pkg::PIX_W-1:0] green;
  logic [rgbhsv_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic                       valid;
  logic                       ready;
  logic [rgbhsv_pkg::HUE_W-1:0] hue;
  logic [rgbhsv_pkg::PCT_W-1:0] saturation;
  logic [rgbhsv_pkg::PCT_W-1:0] brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

### rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter: 8-bit RGB pixel to HSV in degrees and percent
// Five-stage pipeline, one pixel per clock unless stalled, exact half-up rounding.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock while the output is not held off and
// returns one HSV transaction per pixel, in order. The rate is set by the two
// reciprocal dividers (hue and saturation), each split over two register
// stages so a new pixel can enter every cycle unless the output stalls.
// Hue is 0..360 (359.5 and up rounds to 360), saturation and brightness are
// 0..100. A grey or black pixel gives hue and saturation of zero. Each stage
// keeps its own valid bit and takes new data when it is empty or its
// successor moves, so bubbles close up and a stall at the output backs the
// pipeline up without losing or repeating a transaction.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter (
  input  logic          clk_i,
  input  logic          rst_ni,
  rgbhsv_pix_if.sink    pix_i,
  rgbhsv_hsv_if.source  hsv_o
);
  import rgbhsv_pkg::*;

  // Stage map: 0,1 front end; 2,3 dividers; 4 output register
  localparam int unsigned NSTAGE = 5;

  logic [NSTAGE-1:0] vld_q, vld_d, rdy;
  prep_en_t          prep_en;
  div_en_t           div_en;
  prep_t             prep_res;
  logic [QUOT_W-1:0] hue_quot, sat_quot;

  // Value and grey flag ride alongside the dividers
  logic [PCT_W-1:0]  val_s2_q, val_s3_q;
  logic              zero_s2_q, zero_s3_q;

  // Output register
  logic [HUE_W-1:0]  hue_q;
  logic [PCT_W-1:0]  sat_q, bri_q;

  // A stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NSTAGE-1] = ~vld_q[NSTAGE-1] | hsv_o.ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = ~vld_q[k] | rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = pix_i.valid;
    for (int k = 1; k < NSTAGE; k++) begin
      if (rdy[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign pix_i.ready = rdy[0];
  assign prep_en.a   = rdy[0];
  assign prep_en.b   = rdy[1];
  assign div_en.s1   = rdy[2];
  assign div_en.s2   = rdy[3];

  rgbhsv_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (prep_en),
    .red_i   (pix_i.red),
    .green_i (pix_i.green),
    .blue_i  (pix_i.blue),
    .res_o   (prep_res)
  );

  // hue = round(num / diff)
  rgbhsv_div u_div_hue (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .num_i  (prep_res.hue_num),
    .den_i  (prep_res.diff),
    .quot_o (hue_quot)
  );

  // saturation = round(100 * diff / max)
  rgbhsv_div u_div_sat (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .num_i  (prep_res.sat_num),
    .den_i  (prep_res.mx),
    .quot_o (sat_quot)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      val_s2_q  <= prep_res.val;
      zero_s2_q <= prep_res.zero;
    end
    if (rdy[3]) begin
      val_s3_q  <= val_s2_q;
      zero_s3_q <= zero_s2_q;
    end
  end

  // Grey pixel: divisor was zero, quotients are meaningless
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      hue_q <= zero_s3_q ? '0 : hue_quot[HUE_W-1:0];
      sat_q <= zero_s3_q ? '0 : sat_quot[PCT_W-1:0];
      bri_q <= val_s3_q;
    end
  end

  assign hsv_o.valid      = vld_q[NSTAGE-1];
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.brightness = bri_q;

endmodule

### rtl/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// rgbhsv_prep: front end of the converter
// Stage A finds max, min and sector; stage B forms the rounded dividends
// for hue and saturation and the value percentage.
// ----------------------------------------------------------------------------
module rgbhsv_prep (
  input  logic                         clk_i,
  input  rgbhsv_pkg::prep_en_t         en_i,
  input  logic [rgbhsv_pkg::PIX_W-1:0] red_i,
  input  logic [rgbhsv_pkg::PIX_W-1:0] green_i,
  input  logic [rgbhsv_pkg::PIX_W-1:0] blue_i,
  output rgbhsv_pkg::prep_t            res_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned VAL_X_W = 16;

  // Stage A
  logic [PIX_W-1:0]        mx_d, mn_d, a_mx_q, a_diff_q;
  logic signed [PIX_W:0]   delta_d, a_delta_q;
  sector_e                 sect_d, a_sect_q;

  // Stage B
  logic signed [NUM_W-1:0] base_s, step_s, sum_s, num_s;
  logic [VAL_X_W-1:0]      val_x, val_t;
  prep_t                   res_d, res_q;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sect_d  = SECT_RED;
      mx_d    = red_i;
      delta_d = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      sect_d  = SECT_GREEN;
      mx_d    = green_i;
      delta_d = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      sect_d  = SECT_BLUE;
      mx_d    = blue_i;
      delta_d = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d) mn_d = blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      a_mx_q    <= mx_d;
      a_diff_q  <= mx_d - mn_d;
      a_delta_q <= delta_d;
      a_sect_q  <= sect_d;
    end
  end

  always_comb begin
    unique case (a_sect_q)
      SECT_GREEN: base_s = signed'(NUM_W'(a_diff_q) * NUM_W'(HUE_G_DEG));
      SECT_BLUE:  base_s = signed'(NUM_W'(a_diff_q) * NUM_W'(HUE_B_DEG));
      default:    base_s = '0;
    endcase
    step_s = NUM_W'(a_delta_q) * signed'(NUM_W'(HUE_STEP_DEG));
    sum_s  = base_s + step_s;
    // wrap negative hue into range before rounding
    if (sum_s < 0) begin
      num_s = sum_s + signed'(NUM_W'(a_diff_q) * NUM_W'(HUE_FULL_DEG));
    end else begin
      num_s = sum_s;
    end

    // round(100*mx/255) = floor((100*mx + 127) / 255), x/255 by shift trick
    val_x = VAL_X_W'(a_mx_q) * VAL_X_W'(PCT_SCALE) + VAL_X_W'(VAL_BIAS);
    val_t = (val_x + VAL_X_W'(1) + (val_x >> 8)) >> 8;

    res_d.hue_num = DIV_NUM_W'(unsigned'(num_s)) + DIV_NUM_W'(a_diff_q >> 1);
    res_d.sat_num = DIV_NUM_W'(a_diff_q) * DIV_NUM_W'(PCT_SCALE)
                  + DIV_NUM_W'(a_mx_q >> 1);
    res_d.diff    = a_diff_q;
    res_d.mx      = a_mx_q;
    res_d.val     = val_t[PCT_W-1:0];
    res_d.zero    = (a_diff_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/rgbhsv_div.sv
// ----------------------------------------------------------------------------
// rgbhsv_div: pipelined small-divisor divider
// Quotient estimate from a reciprocal table and one multiply, then a
// remainder check that corrects the estimate by at most one.
// ----------------------------------------------------------------------------
module rgbhsv_div (
  input  logic                             clk_i,
  input  rgbhsv_pkg::div_en_t              en_i,
  input  logic [rgbhsv_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [rgbhsv_pkg::DIV_DEN_W-1:0] den_i,
  output logic [rgbhsv_pkg::QUOT_W-1:0]    quot_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned TAB_N  = 2 ** DIV_DEN_W;
  localparam int unsigned PROD_W = DIV_NUM_W + RECIP_W;

  logic [RECIP_W-1:0]   recip_tab [TAB_N];
  logic [PROD_W-1:0]    prod;
  logic [QUOT_W-1:0]    s1_q_q, s2_q_q;
  logic [DIV_NUM_W-1:0] s1_num_q, qd, rem_full;
  logic [DIV_DEN_W-1:0] s1_den_q, s2_den_q;
  logic [REM_W-1:0]     s2_rem_q;

  // floor(2^RECIP_SHIFT / d); entry zero is read only for grey pixels, whose quotients are dropped
  for (genvar gi = 0; gi < TAB_N; gi++) begin : g_recip
    localparam int unsigned RV = (gi == 0) ? 0 : ((1 << RECIP_SHIFT) / ((gi == 0) ? 1 : gi));
    assign recip_tab[gi] = RECIP_W'(RV);
  end

  assign prod = PROD_W'(num_i) * PROD_W'(recip_tab[den_i]);

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_q_q   <= prod[RECIP_SHIFT +: QUOT_W];
      s1_num_q <= num_i;
      s1_den_q <= den_i;
    end
  end

  // estimate is low by at most one, so remainder stays below 2*den
  assign qd       = DIV_NUM_W'(s1_q_q * QUOT_W'(s1_den_q));
  assign rem_full = s1_num_q - qd;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_q_q   <= s1_q_q;
      s2_rem_q <= rem_full[REM_W-1:0];
      s2_den_q <= s1_den_q;
    end
  end

  assign quot_o = s2_q_q + QUOT_W'(s2_rem_q >= REM_W'(s2_den_q));

endmodule
